// ===== src/vrt_pkg.sv =====
// Shared types and codes for the velocity rescaling thermostat.
package vrt_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RESCALE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO_KE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_NODE_MASS  = 2'd1,
    CFG_TARGET_KT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         node_index;
    logic signed [31:0] in_vx;
    logic signed [31:0] in_vy;
    logic signed [31:0] in_vz;
  } vrt_in_t;

  typedef struct packed {
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic signed [31:0] out_vz;
    logic [1:0]         status;
    logic [31:0]        scale_factor;
  } vrt_out_t;

endpackage

// ===== src/vrt_mem.sv =====
// Velocity store: one write port, one read port, registered read data.
module vrt_mem #(
  parameter int AW = 10,
  parameter int DW = 96
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vrt_mul.sv =====
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
module vrt_mul #(
  parameter int AW = 78,
  parameter int BW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int CNTW = $clog2(BW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNTW-1:0]  cnt_q;
  logic [AW-1:0]    a_q;
  logic [AW+BW-1:0] prod_q;
  logic [AW:0]      sum;

  assign sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      prod_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(BW);
        a_q    <= a_i;
        prod_q <= {{AW{1'b0}}, b_i};
      end else if (busy_q) begin
        prod_q <= {sum, prod_q[BW-1:1]};
        cnt_q  <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== src/vrt_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module vrt_div #(
  parameter int NW = 109,
  parameter int DW = 110
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   d_q;
  logic [DW-1:0]   rem_q;
  logic [NW-1:0]   q_q;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {rem_q, q_q[NW-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      d_q    <= '0;
      rem_q  <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
        d_q    <= divisor_i;
        rem_q  <= '0;
        q_q    <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q_q   <= {q_q[NW-2:0], ge};
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== src/vrt_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
module vrt_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  assign rem_sh = {rem_q, x_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
        x_q    <= x_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        x_q    <= {x_q[61:0], 2'b00};
        rem_q  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_q <= {root_q[30:0], ge};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/velocity_rescale_thermostat.sv =====
// Velocity rescaling thermostat: velocity store, sequencer and output register.
//
// Requests arrive on in_valid_i/in_req_i and are taken when in_stall_o is low.
// Each request yields one response on out_valid_o/out_rsp_o, held until
// out_stall_i is low. Configuration (node count, mass, target kT) is written
// over cfg_valid_i/cfg_index_i/cfg_data_i, always ready; the user must write it
// only while the block idles, which the block does not enforce itself. A write
// is answered from idle, a read via ST_RD_WAIT and one synchronous memory read.
// A rescale makes three passes over the first n nodes of the store: a sum for
// the mean, a sum of squares and the scaling pass, plus four serial divisions
// and a square root; zero energy ends it before the scale-factor division.
// The bit-serial multiplier is shared by the sum of squares, the energy
// product and the scaling pass.
// One request is in flight at a time; the next is taken when the response
// register is free or being emptied in the same cycle. A stalled response
// simply holds. Reset clears the sequencer, the response register, the
// configuration (n=1, mass=1.0, kT=1.0) and the last scale factor; the store
// contents are undefined until written.
module velocity_rescale_thermostat
  import vrt_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int VEL_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  vrt_in_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vrt_out_t    out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int V    = VEL_WIDTH;
  localparam int AW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int SW   = V + AW + 1;
  localparam int SSW  = 2 * V + AW + 2;
  localparam int MA   = SSW;
  localparam int MB   = (V > 32) ? V : 32;
  localparam int DNW  = SSW + 32;
  localparam int NKW  = CW + 34;
  localparam int NW   = (NKW + 64 > SW) ? NKW + 64 : SW;
  localparam int SCW  = V + 32;

  localparam logic signed [64:0] VMAX = (65'sd1 <<< (V - 1)) - 65'sd1;
  localparam logic signed [64:0] VMIN = -VMAX - 65'sd1;
  localparam logic signed [64:0] OMAX = 65'sd2147483647;
  localparam logic signed [64:0] OMIN = -65'sd2147483648;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_WAIT,
    ST_SUM_RD, ST_SUM_ACC, ST_MEAN_DIV, ST_MEAN_WAIT,
    ST_SQ_RD, ST_SQ_DATA, ST_SQ_MUL, ST_SQ_WAIT,
    ST_EN_MUL, ST_EN_WAIT, ST_AL_DIV, ST_AL_WAIT, ST_SQRT, ST_SQRT_WAIT,
    ST_SC_RD, ST_SC_DATA, ST_SC_MUL, ST_SC_WAIT, ST_SC_WR
  } state_e;

  function automatic logic signed [V-1:0] sat_vel(input logic signed [64:0] x);
    logic signed [64:0] r;
    r = (x > VMAX) ? VMAX : ((x < VMIN) ? VMIN : x);
    return r[V-1:0];
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [V-1:0] x);
    logic signed [64:0] e;
    logic signed [64:0] r;
    e = 65'(x);
    r = (e > OMAX) ? OMAX : ((e < OMIN) ? OMIN : e);
    return r[31:0];
  endfunction

  state_e             state_q;
  logic               out_valid_q;
  vrt_out_t           out_q;
  logic [10:0]        node_count_q;
  logic [31:0]        node_mass_q;
  logic [31:0]        target_kt_q;
  logic [31:0]        last_alpha_q;
  logic [CW-1:0]      n_q;
  logic [CW-1:0]      idx_q;
  logic [1:0]         k_q;
  logic signed [SW-1:0] sum_q [3];
  logic signed [V-1:0]  mean_q [3];
  logic signed [V-1:0]  vel_q [3];
  logic signed [V-1:0]  new_q [3];
  logic [SSW-1:0]     ssq_q;
  logic [DNW-1:0]     den_q;
  logic [NKW-1:0]     nk_q;

  logic               in_acc;
  logic               in_range;
  logic [AW-1:0]      addr_in;
  logic [CW-1:0]      n_eff;
  logic               idle_done;
  status_e            idle_status;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [3*V-1:0]     mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [3*V-1:0]     mem_rdata;
  logic signed [V-1:0] rd_v [3];

  logic signed [V:0]  dev;
  logic signed [V:0]  dev_abs;
  logic               dev_neg;
  logic [V-1:0]       mag;
  logic signed [SW-1:0] s_cur;
  logic [SW-1:0]      s_mag;

  logic               mul_start;
  logic [MA-1:0]      mul_a;
  logic [MB-1:0]      mul_b;
  logic               mul_done;
  logic [MA+MB-1:0]   mul_p;
  logic               div_start;
  logic [NW-1:0]      div_n;
  logic [DNW-1:0]     div_d;
  logic               div_done;
  logic [NW-1:0]      div_q;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;

  logic [95:0]        rnd;
  logic [62:0]        res;
  logic signed [64:0] scaled;
  logic signed [V-1:0] mean_neg;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign in_range = 32'(in_req_i.node_index) < 32'(MAX_NODES);
  assign addr_in  = AW'(in_req_i.node_index);
  assign n_eff    = (32'(node_count_q) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                         : CW'(node_count_q);

  // immediate response and its status for a request taken in idle
  always_comb begin
    idle_done   = 1'b1;
    idle_status = STAT_OK;
    unique case (in_req_i.cmd)
      CMD_WRITE: begin
        if (!in_range) idle_status = STAT_RANGE;
      end
      CMD_READ: begin
        if (in_range) idle_done = 1'b0;
        else idle_status = STAT_RANGE;
      end
      CMD_RESCALE: begin
        if (n_eff == '0) idle_status = STAT_ZERO_KE;
        else idle_done = 1'b0;
      end
      default: ;
    endcase
  end

  assign rd_v[0] = mem_rdata[V-1:0];
  assign rd_v[1] = mem_rdata[2*V-1:V];
  assign rd_v[2] = mem_rdata[3*V-1:2*V];

  // deviation of the current component from its mean
  assign dev      = {vel_q[k_q][V-1], vel_q[k_q]} - {mean_q[k_q][V-1], mean_q[k_q]};
  assign dev_neg  = dev[V];
  assign dev_abs  = dev_neg ? -dev : dev;
  assign mag      = dev_abs[V-1:0];
  assign s_cur    = sum_q[k_q];
  assign s_mag    = s_cur[SW-1] ? -s_cur : s_cur;
  assign mean_neg = -V'(div_q[SW-1:0]);

  // deviation * alpha, rounded half away from zero, then mean added back
  assign rnd    = 96'(mul_p[SCW-1:0]) + 96'h8000;
  assign res    = (|rnd[95:78]) ? {1'b1, 62'd0} : {1'b0, rnd[77:16]};
  assign scaled = 65'(mean_q[k_q]) + (dev_neg ? -65'(res) : 65'(res));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = {new_q[2], new_q[1], new_q[0]};
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    if (in_acc && in_range && in_req_i.cmd == CMD_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = addr_in;
      mem_wdata = {sat_vel(65'(in_req_i.in_vz)), sat_vel(65'(in_req_i.in_vy)),
                   sat_vel(65'(in_req_i.in_vx))};
    end
    if (in_acc && in_range && in_req_i.cmd == CMD_READ) begin
      mem_re    = 1'b1;
      mem_raddr = addr_in;
    end
    if (state_q == ST_SUM_RD || state_q == ST_SQ_RD || state_q == ST_SC_RD) begin
      mem_re = 1'b1;
    end
    if (state_q == ST_SC_WR) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = MA'(mag);
    mul_b     = MB'(mag);
    unique case (state_q)
      ST_SQ_MUL: mul_start = 1'b1;
      ST_EN_MUL: begin
        mul_start = 1'b1;
        mul_a     = ssq_q;
        mul_b     = MB'(node_mass_q);
      end
      ST_SC_MUL: begin
        mul_start = 1'b1;
        mul_b     = MB'(last_alpha_q);
      end
      default: ;
    endcase
  end

  assign div_start  = (state_q == ST_MEAN_DIV) || (state_q == ST_AL_DIV);
  assign div_n      = (state_q == ST_AL_DIV) ? NW'({nk_q, 64'd0}) : NW'(s_mag);
  assign div_d      = (state_q == ST_AL_DIV) ? den_q : DNW'(n_q);
  assign sqrt_start = (state_q == ST_SQRT);

  vrt_mem #(.AW(AW), .DW(3 * V)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  vrt_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  vrt_div #(.NW(NW), .DW(DNW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  vrt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (div_q[63:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      node_count_q <= 11'd1;
      node_mass_q  <= 32'd65536;
      target_kt_q  <= 32'd65536;
      last_alpha_q <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      sum_q        <= '{default: '0};
      mean_q       <= '{default: '0};
      vel_q        <= '{default: '0};
      new_q        <= '{default: '0};
      ssq_q        <= '0;
      den_q        <= '0;
      nk_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_NODE_COUNT: node_count_q <= cfg_data_i[10:0];
          CFG_NODE_MASS:  node_mass_q  <= cfg_data_i;
          CFG_TARGET_KT:  target_kt_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            out_valid_q <= idle_done;
            out_q       <= {96'd0, idle_status, last_alpha_q};
            unique case (in_req_i.cmd)
              CMD_READ: begin
                if (in_range) state_q <= ST_RD_WAIT;
              end
              CMD_RESCALE: begin
                n_q   <= n_eff;
                idx_q <= '0;
                sum_q <= '{default: '0};
                if (n_eff != '0) state_q <= ST_SUM_RD;
              end
              default: ;
            endcase
          end else if (!out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_RD_WAIT: begin
          out_q       <= {sat_out(rd_v[0]), sat_out(rd_v[1]), sat_out(rd_v[2]),
                          out_q.status, out_q.scale_factor};
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_SUM_RD: state_q <= ST_SUM_ACC;
        ST_SUM_ACC: begin
          sum_q[0] <= sum_q[0] + SW'(rd_v[0]);
          sum_q[1] <= sum_q[1] + SW'(rd_v[1]);
          sum_q[2] <= sum_q[2] + SW'(rd_v[2]);
          if (idx_q == n_q - CW'(1)) begin
            k_q     <= '0;
            state_q <= ST_MEAN_DIV;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= ST_SUM_RD;
          end
        end
        ST_MEAN_DIV: state_q <= ST_MEAN_WAIT;
        ST_MEAN_WAIT: begin
          if (div_done) begin
            mean_q[k_q] <= s_cur[SW-1] ? mean_neg : V'(div_q[SW-1:0]);
            if (k_q == 2'd2) begin
              idx_q   <= '0;
              ssq_q   <= '0;
              nk_q    <= NKW'(((CW + 2)'(n_q) * (CW + 2)'(3))) * NKW'(target_kt_q);
              state_q <= ST_SQ_RD;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_MEAN_DIV;
            end
          end
        end
        ST_SQ_RD: state_q <= ST_SQ_DATA;
        ST_SQ_DATA: begin
          vel_q   <= rd_v;
          k_q     <= '0;
          state_q <= ST_SQ_MUL;
        end
        ST_SQ_MUL: state_q <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (mul_done) begin
            ssq_q <= ssq_q + SSW'(mul_p[2*V-1:0]);
            if (k_q != 2'd2) begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_SQ_MUL;
            end else if (idx_q == n_q - CW'(1)) begin
              state_q <= ST_EN_MUL;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= ST_SQ_RD;
            end
          end
        end
        ST_EN_MUL: state_q <= ST_EN_WAIT;
        ST_EN_WAIT: begin
          if (mul_done) begin
            den_q <= mul_p[DNW-1:0];
            if (mul_p[DNW-1:0] == '0) begin
              out_valid_q  <= 1'b1;
              out_q.status <= STAT_ZERO_KE;
              state_q      <= ST_IDLE;
            end else begin
              state_q <= ST_AL_DIV;
            end
          end
        end
        ST_AL_DIV: state_q <= ST_AL_WAIT;
        ST_AL_WAIT: begin
          if (div_done) begin
            if (|div_q[NW-1:64]) begin
              last_alpha_q <= '1;
              idx_q        <= '0;
              state_q      <= ST_SC_RD;
            end else begin
              state_q <= ST_SQRT;
            end
          end
        end
        ST_SQRT: state_q <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            last_alpha_q <= sqrt_root;
            idx_q        <= '0;
            state_q      <= ST_SC_RD;
          end
        end
        ST_SC_RD: state_q <= ST_SC_DATA;
        ST_SC_DATA: begin
          vel_q   <= rd_v;
          k_q     <= '0;
          state_q <= ST_SC_MUL;
        end
        ST_SC_MUL: state_q <= ST_SC_WAIT;
        ST_SC_WAIT: begin
          if (mul_done) begin
            new_q[k_q] <= sat_vel(scaled);
            if (k_q == 2'd2) begin
              state_q <= ST_SC_WR;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_SC_MUL;
            end
          end
        end
        ST_SC_WR: begin
          if (idx_q == n_q - CW'(1)) begin
            out_valid_q        <= 1'b1;
            out_q.scale_factor <= last_alpha_q;
            state_q            <= ST_IDLE;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= ST_SC_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD_WAIT |=> out_valid_q)
    else $error("read data not presented after memory latency");

  a_alpha_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_alpha_q) |-> $past(state_q) == ST_AL_WAIT ||
                               $past(state_q) == ST_SQRT_WAIT)
    else $error("scale factor changed outside the alpha computation");

  a_wr_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SC_WR |-> idx_q < n_q)
    else $error("rescale write beyond node count");

endmodule

// ===== bench/velocity_rescale_thermostat_tb.sv =====
// Self-checking bench for the velocity rescaling thermostat: write/read/rescale traffic.
`timescale 1ns / 100ps

module velocity_rescale_thermostat_tb;
  import vrt_pkg::*;

  localparam int          NODES      = 1024;
  localparam int          FILL       = 448;
  localparam int          HOLD_LEN   = 600;
  localparam longint      LIMIT      = 4000000;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  vrt_in_t     in_req_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  vrt_out_t    out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  velocity_rescale_thermostat dut (.*);

  // shadow state
  logic signed [31:0] vel_mem [3][NODES];
  logic [10:0]        cfg_count = 11'd1;
  logic [31:0]        cfg_mass  = 32'd65536;
  logic [31:0]        cfg_kt    = 32'd65536;
  logic [31:0]        last_alpha = '0;

  vrt_out_t expected_rsp [$];
  int       errors = 0;
  int       n_items = 0, n_rescale = 0, n_zero_ke = 0, n_sat_alpha = 0;
  int       tx_idle_pct = 0, rx_idle_pct = 0;
  int       hold_left = 0;
  bit       hold_req = 0;
  longint   cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // response side back-pressure
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < rx_idle_pct);
  end

  function automatic logic [31:0] isqrt64(logic [63:0] q);
    logic [31:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = 64'(r | (32'd1 << b));
      if (t * t <= q) r = t[31:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] rescale_store();
    int unsigned         n;
    longint              sum, dev;
    longint              mean [3];
    logic [63:0]         mag;
    logic [255:0]        energy, num, q;
    logic [31:0]         alpha;
    logic [127:0]        res;
    logic signed [127:0] v;
    n = (cfg_count > NODES) ? NODES : cfg_count;
    if (n == 0) return STAT_ZERO_KE;
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int i = 0; i < n; i++) sum += longint'(vel_mem[k][i]);
      mean[k] = sum / longint'(n);
    end
    energy = '0;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < n; i++) begin
        dev = longint'(vel_mem[k][i]) - mean[k];
        mag = (dev < 0) ? 64'(-dev) : 64'(dev);
        energy += 256'(mag) * 256'(mag);
      end
    energy = energy * 256'(cfg_mass);
    if (energy == 0) return STAT_ZERO_KE;
    num = (256'(3) * 256'(n) * 256'(cfg_kt)) << 64;
    if ((energy << 64) <= num) begin
      alpha = '1;
      n_sat_alpha++;
    end else begin
      q = num / energy;
      alpha = isqrt64(q[63:0]);
    end
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < n; i++) begin
        dev = longint'(vel_mem[k][i]) - mean[k];
        mag = (dev < 0) ? 64'(-dev) : 64'(dev);
        res = (128'(mag) * 128'(alpha) + 128'h8000) >> 16;
        if (res >= (128'd1 << 62)) res = 128'd1 << 62;
        v = 128'(mean[k]) + ((dev < 0) ? -$signed(res) : $signed(res));
        if (v > 128'sd2147483647) v = 128'sd2147483647;
        else if (v < -128'sd2147483648) v = -128'sd2147483648;
        vel_mem[k][i] = v[31:0];
      end
    last_alpha = alpha;
    return STAT_OK;
  endfunction

  function automatic vrt_out_t predict_response(vrt_in_t it);
    vrt_out_t r;
    r = '0;
    case (it.cmd)
      CMD_WRITE: begin
        vel_mem[0][it.node_index] = it.in_vx;
        vel_mem[1][it.node_index] = it.in_vy;
        vel_mem[2][it.node_index] = it.in_vz;
      end
      CMD_READ: begin
        r.out_vx = vel_mem[0][it.node_index];
        r.out_vy = vel_mem[1][it.node_index];
        r.out_vz = vel_mem[2][it.node_index];
      end
      CMD_RESCALE: begin
        r.status = rescale_store();
        n_rescale++;
        if (r.status == STAT_ZERO_KE) n_zero_ke++;
      end
      default: ;
    endcase
    r.scale_factor = last_alpha;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    errors++;
    $display("%0t %s mismatch: expected %h actual %h", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    vrt_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected response: expected none actual %h", $time, out_rsp_o);
      end else begin
        e = expected_rsp.pop_front();
        if (out_rsp_o.out_vx !== e.out_vx) report("out_vx", e.out_vx, out_rsp_o.out_vx);
        if (out_rsp_o.out_vy !== e.out_vy) report("out_vy", e.out_vy, out_rsp_o.out_vy);
        if (out_rsp_o.out_vz !== e.out_vz) report("out_vz", e.out_vz, out_rsp_o.out_vz);
        if (out_rsp_o.status !== e.status) report("status", e.status, out_rsp_o.status);
        if (out_rsp_o.scale_factor !== e.scale_factor)
          report("scale_factor", e.scale_factor, out_rsp_o.scale_factor);
      end
    end
  end

  task automatic send_request(vrt_in_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_rsp.push_back(predict_response(it));
    n_items++;
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [9:0] idx,
                          logic [31:0] vx = '0, logic [31:0] vy = '0, logic [31:0] vz = '0);
    vrt_in_t it;
    it.cmd = cmd;
    it.node_index = idx;
    it.in_vx = vx;
    it.in_vy = vy;
    it.in_vz = vz;
    send_request(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NODE_COUNT: cfg_count = data[10:0];
      CFG_NODE_MASS:  cfg_mass  = data;
      CFG_TARGET_KT:  cfg_kt    = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] n, logic [31:0] mass, logic [31:0] kt);
    wait_drained();
    cfg_write(CFG_NODE_COUNT, n);
    cfg_write(CFG_NODE_MASS, mass);
    cfg_write(CFG_TARGET_KT, kt);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'($urandom_range(0, 262144))
                                     : -32'($urandom_range(0, 262144));
      2: case ($urandom_range(3))
           0: return 32'h7fffffff;
           1: return 32'h80000000;
           2: return 32'h0;
           default: return 32'hffffffff;
         endcase
      default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
    endcase
  endfunction

  function automatic logic [31:0] rand_cfg32();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hffffffff;
      2: return 32'd1;
      default: return $urandom_range(32'h1000, 32'h100000);
    endcase
  endfunction

  task automatic send_random(int unsigned hot);
    int unsigned pick;
    logic [1:0]  cmd;
    logic [9:0]  idx;
    pick = $urandom_range(99);
    cmd = (pick < 45) ? CMD_WRITE : (pick < 85) ? CMD_READ :
          (pick < 95) ? CMD_RESCALE : CMD_UNUSED;
    idx = ($urandom_range(99) < 70) ? 10'($urandom_range(0, hot))
                                    : 10'($urandom_range(0, FILL - 1));
    send_cmd(cmd, idx, rand_vel(), rand_vel(), rand_vel());
  endtask

  // low part of the store written once so later reads and rescales never touch unwritten data
  task automatic test_fill_store();
    for (int i = 0; i < FILL; i++) send_cmd(CMD_WRITE, 10'(i), rand_vel(), rand_vel(), rand_vel());
  endtask

  task automatic test_directed();
    set_config(1, 32'd65536, 32'd65536);
    send_cmd(CMD_RESCALE, 0);
    send_cmd(CMD_READ, 0);
    send_cmd(CMD_WRITE, 0, 32'h7fffffff, 32'h80000000, 32'h0);
    send_cmd(CMD_WRITE, 1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_cmd(CMD_WRITE, 10'h3ff, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
    send_cmd(CMD_READ, 10'h3ff);
    send_cmd(CMD_UNUSED, 10'h155, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    set_config(2, 32'd65536, 32'd65536);
    send_cmd(CMD_RESCALE, 0);
    send_cmd(CMD_READ, 0);
    send_cmd(CMD_READ, 1);
    send_cmd(CMD_WRITE, 2, 32'h00010000, 32'hffff0000, 32'h00008000);
    set_config(3, 32'd65536, 32'd0);
    send_cmd(CMD_RESCALE, 0);
    send_cmd(CMD_READ, 2);
    set_config(3, 32'd0, 32'd65536);
    send_cmd(CMD_RESCALE, 0);
    send_cmd(CMD_WRITE, 0, 32'd1, 32'd0, 32'd0);
    send_cmd(CMD_WRITE, 1, 32'd0, 32'd0, 32'd0);
    set_config(2, 32'd1, 32'hffffffff);
    send_cmd(CMD_RESCALE, 0);
    send_cmd(CMD_READ, 0);
    send_cmd(CMD_READ, 1);
    set_config(0, 32'hffffffff, 32'hffffffff);
    send_cmd(CMD_RESCALE, 0);
  endtask

  task automatic test_random(int tx, int rx, int count);
    int unsigned hot;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        hot = $urandom_range(1, 12);
        set_config(hot, rand_cfg32(), ($urandom_range(9) == 0) ? 32'd0 : rand_cfg32());
      end
      send_random(hot);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drained();
    hold_req = 1;
    for (int i = 0; i < 30; i++) send_random(15);
  endtask

  task automatic test_full_store();
    tx_idle_pct = 0;
    rx_idle_pct = 10;
    set_config(FILL, 32'd65536, rand_cfg32());
    send_cmd(CMD_RESCALE, 0);
    send_cmd(CMD_READ, 10'(FILL - 1));
    set_config(300, rand_cfg32(), rand_cfg32());
    send_cmd(CMD_RESCALE, 0);
    send_cmd(CMD_READ, 10'h0c8);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_store();
    test_directed();
    test_random(31, 67, 80);
    test_random(67, 31, 80);
    test_random(0, 0, 80);
    test_backpressure();
    test_full_store();
    wait_drained();
    rx_idle_pct = 0;
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests: %0d rescales, %0d with zero energy, %0d with saturated alpha",
             n_items, n_rescale, n_zero_ke, n_sat_alpha);
    $display("Covered stalls on both sides, a long response hold-off and long rescales");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
